// ===== sv/priority_order_dispatcher_macros.svh =====
// Assertion macros for the priority order dispatcher.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef PRIORITY_ORDER_DISPATCHER_MACROS_SVH
`define PRIORITY_ORDER_DISPATCHER_MACROS_SVH

// check cons in the same cycle as ante
`define POD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define POD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pod_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants of the priority order dispatcher.
// No dependencies.
package pod_pkg;

  localparam int MAX_TASKS_DEF = 32;

  localparam int ID_W   = 8;
  localparam int PRIO_W = 8;
  localparam int BURST_W = 16;
  localparam int TOUT_W = 21;
  localparam int CLK_W  = 22;
  localparam int WAIT_W = 26;
  localparam int TURN_W = 27;
  localparam int FRAC_W = 8;
  localparam int AVG_W  = 29;
  localparam int DIV_W  = TURN_W + FRAC_W;

  typedef struct packed {
    logic [ID_W-1:0]    task_id;
    logic [PRIO_W-1:0]  priority_req;
    logic [BURST_W-1:0] burst;
    logic               last;
  } task_t;

  typedef struct packed {
    logic [ID_W-1:0]    task_id_res;
    logic [PRIO_W-1:0]  prio_out;
    logic [BURST_W-1:0] slice;
    logic [TOUT_W-1:0]  start_time;
    logic [TOUT_W-1:0]  completion_time;
    logic [AVG_W-1:0]   avg_wait;
    logic [AVG_W-1:0]   avg_turnaround;
    logic [AVG_W-1:0]   avg_response;
    logic               final_res;
    logic               dropped;
  } res_t;

  typedef struct packed {
    logic               valid;
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/pod_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One slot of the sorted task chain: insert by priority, shift toward the head on pop.
// Depends on pod_pkg.
module pod_cell import pod_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     new_i,
  input  entry_t     prev_i,
  input  logic       prev_keep_i,
  input  entry_t     next_i,
  output entry_t     entry_o,
  output logic       keep_o
);

  entry_t entry_q, entry_d;
  logic   keep;

  assign keep = entry_q.valid && (entry_q.prio >= new_i.prio);

  always_comb begin
    entry_d = entry_q;
    priority if (ctrl_i.pop) begin
      entry_d = next_i;
    end else if (ctrl_i.ins && !keep) begin
      if (prev_keep_i) begin
        entry_d = new_i;
        entry_d.valid = 1'b1;
      end else begin
        entry_d = prev_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;
  assign keep_o  = keep;

endmodule
`default_nettype wire

// ===== sv/pod_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle.
// Depends on pod_pkg.
module pod_div import pod_pkg::*; #(
  parameter int DW = DIV_W,
  parameter int VW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic [DW-1:0] quot_o,
  output logic          done_o
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quot_q;
  logic [VW-1:0] rem_q;
  logic [CW-1:0] cnt_q;
  logic          run_q;
  logic          done_q;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          fits;

  assign trial = {rem_q, quot_q[DW-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = trial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
    end else if (run_q) begin
      quot_q <= {quot_q[DW-2:0], fits};
      rem_q  <= fits ? diff[VW-1:0] : trial[VW-1:0];
    end
  end

  assign quot_o = quot_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

// ===== sv/priority_order_dispatcher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Top level of the priority order dispatcher: cell chain, dispatch control, averaging.
// Depends on pod_pkg, pod_cell, pod_div and priority_order_dispatcher_macros.svh.
`include "priority_order_dispatcher_macros.svh"

// Tasks load one per cycle while busy is low; each is placed at once in a chain of
// MaxTasks cells kept sorted by priority, highest first, equal priorities in arrival
// order. A task arriving with the store full is dropped and flags the run. The task
// marked last raises busy; the chain then shifts one task out per cycle, giving one
// result strobe per cycle for all but the final task. The final result waits for the
// averages from two restoring dividers, one quotient bit per cycle over 35 bits. Results
// are shown for exactly one cycle on res_valid_o and cannot be held off; the next run
// may start in the cycle the final result is shown.
module priority_order_dispatcher import pod_pkg::*; #(
  parameter int MaxTasks = MAX_TASKS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  input  task_t task_i,
  output logic  busy,
  output logic  res_valid_o,
  output res_t  res_o
);

  localparam int CntW = $clog2(MaxTasks + 1);

  typedef enum logic [1:0] {
    S_LOAD,
    S_DISP,
    S_DIV
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   count_q;
  logic [CntW-1:0]   n_q;
  logic              ovf_q;
  logic [CLK_W-1:0]  clock_q;
  logic [WAIT_W-1:0] wait_q;
  logic [TURN_W-1:0] turn_q;
  logic              div_start_q;
  logic              res_valid_q;
  res_t              res_q;

  entry_t     cell_q [MaxTasks];
  logic       keep   [MaxTasks];
  entry_t     new_entry;
  cell_ctrl_t ctrl;
  logic       accept;
  logic       full;
  logic [CLK_W-1:0] done_time;
  logic [DIV_W-1:0] quot_w;
  logic [DIV_W-1:0] quot_t;
  logic             done_w;
  logic             done_t;

  assign busy      = (state_q != S_LOAD);
  assign accept    = start && !busy;
  assign full      = (count_q == CntW'(MaxTasks));
  assign done_time = clock_q + CLK_W'(cell_q[0].burst);

  assign new_entry.valid = 1'b1;
  assign new_entry.id    = task_i.task_id;
  assign new_entry.prio  = task_i.priority_req;
  assign new_entry.burst = task_i.burst;

  assign ctrl.ins = accept && !full;
  assign ctrl.pop = (state_q == S_DISP);

  for (genvar i = 0; i < MaxTasks; i++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   prev_k;
    if (i == 0) begin : g_head
      assign prev_e = '0;
      assign prev_k = 1'b1;
    end else begin : g_body
      assign prev_e = cell_q[i-1];
      assign prev_k = keep[i-1];
    end
    if (i == MaxTasks - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_link
      assign next_e = cell_q[i+1];
    end
    pod_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_i       (new_entry),
      .prev_i      (prev_e),
      .prev_keep_i (prev_k),
      .next_i      (next_e),
      .entry_o     (cell_q[i]),
      .keep_o      (keep[i])
    );
  end

  pod_div #(.DW(DIV_W), .VW(CntW)) u_div_wait (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i ({1'b0, wait_q, {FRAC_W{1'b0}}}),
    .divisor_i  (n_q),
    .quot_o     (quot_w),
    .done_o     (done_w)
  );

  pod_div #(.DW(DIV_W), .VW(CntW)) u_div_turn (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i ({turn_q, {FRAC_W{1'b0}}}),
    .divisor_i  (n_q),
    .quot_o     (quot_t),
    .done_o     (done_t)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      n_q         <= '0;
      ovf_q       <= 1'b0;
      clock_q     <= '0;
      wait_q      <= '0;
      turn_q      <= '0;
      div_start_q <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      div_start_q <= 1'b0;
      res_valid_q <= 1'b0;
      unique case (state_q)
        S_LOAD: begin
          if (accept) begin
            if (full) begin
              ovf_q <= 1'b1;
              n_q   <= count_q;
            end else begin
              count_q <= count_q + 1'b1;
              n_q     <= count_q + 1'b1;
            end
            if (task_i.last) begin
              state_q <= S_DISP;
            end
          end
        end
        S_DISP: begin
          clock_q                     <= done_time;
          wait_q                      <= wait_q + WAIT_W'(clock_q);
          turn_q                      <= turn_q + TURN_W'(done_time);
          count_q                     <= count_q - 1'b1;
          res_q.task_id_res           <= cell_q[0].id;
          res_q.prio_out              <= cell_q[0].prio;
          res_q.slice                 <= cell_q[0].burst;
          res_q.start_time            <= clock_q[TOUT_W-1:0];
          res_q.completion_time       <= done_time[TOUT_W-1:0];
          res_q.avg_wait              <= '0;
          res_q.avg_turnaround        <= '0;
          res_q.avg_response          <= '0;
          res_q.final_res             <= 1'b0;
          res_q.dropped               <= ovf_q;
          if (count_q == CntW'(1)) begin
            div_start_q <= 1'b1;
            state_q     <= S_DIV;
          end else begin
            res_valid_q <= 1'b1;
          end
        end
        S_DIV: begin
          if (done_w && done_t) begin
            res_q.avg_wait       <= quot_w[AVG_W-1:0];
            res_q.avg_turnaround <= quot_t[AVG_W-1:0];
            res_q.avg_response   <= quot_w[AVG_W-1:0];
            res_q.final_res      <= 1'b1;
            res_valid_q          <= 1'b1;
            ovf_q                <= 1'b0;
            clock_q              <= '0;
            wait_q               <= '0;
            turn_q               <= '0;
            state_q              <= S_LOAD;
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `POD_ASSERT_NEXT(a_last_busy, accept && task_i.last, busy, "last transfer did not raise busy")
  `POD_ASSERT_NOW(a_disp_head, state_q == S_DISP, cell_q[0].valid, "dispatch from empty chain")
  `POD_ASSERT_NOW(a_final_idle, res_valid_o && res_o.final_res, !busy, "final result while busy")

endmodule
`default_nettype wire
